// ===== src/dgvt_pkg.sv =====
// Shared constants, types and state encodings of the gesture volume tracker.
package dgvt_pkg;

  localparam int MEDIAN_TAPS   = 5;
  localparam int HISTORY_DEPTH = 8;
  localparam int NOISE_LIMIT   = 2;
  localparam int TREND_MIN     = 4;

  localparam int MED_IW   = $clog2(MEDIAN_TAPS);
  localparam int HIST_IW  = $clog2(HISTORY_DEPTH);
  localparam int NOISE_W  = $clog2(NOISE_LIMIT + 1);
  localparam int VAL_W    = 11;
  localparam int CTR_W    = 13;
  localparam int PROD_W   = CTR_W + 8;
  localparam int DVD_W    = PROD_W + 8;
  localparam int DIV_CW   = $clog2(DVD_W + 1);
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 16;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [CTR_W-1:0] ctr_t;

  localparam val_t VAL_NONE = -11'sd1;

  typedef enum logic [1:0] {
    SWIPE_NONE = 2'd0,
    SWIPE_ON   = 2'd1,
    SWIPE_OFF  = 2'd2
  } swipe_t;

  typedef enum logic [1:0] {
    MOT_STOP = 2'd0,
    MOT_UP   = 2'd1,
    MOT_DOWN = 2'd2
  } motion_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_SENSOR_MIN = 3'd0,
    REG_SENSOR_MAX = 3'd1,
    REG_OUTPUT_MIN = 3'd2,
    REG_OUTPUT_MAX = 3'd3,
    REG_PAUSE_MS   = 3'd4,
    REG_SPAN_THR   = 3'd5,
    REG_MAX_STEP   = 3'd6,
    REG_DEADBAND   = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MEDGO, ST_MEDIAN, ST_PAUSE, ST_SCAN, ST_TRACK,
    ST_MUL, ST_DIVGO, ST_DIV, ST_CLAMP, ST_FINISH
  } top_state_t;

  typedef enum logic [1:0] {MS_IDLE, MS_LOAD, MS_CMP} med_state_t;

  typedef enum logic [1:0] {TS_IDLE, TS_J, TS_K, TS_DONE} trend_state_t;

endpackage

// ===== src/dgvt_in_if.sv =====
// Input channel: one raw sample with its millisecond time.
interface dgvt_in_if import dgvt_pkg::*;;
  logic        valid;
  logic        ready;
  logic [9:0]  sample;
  logic [31:0] now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

// ===== src/dgvt_out_if.sv =====
// Result channel: filtered reading, presence, gesture and level.
interface dgvt_out_if import dgvt_pkg::*;;
  logic        valid;
  logic        ready;
  val_t        filtered;
  logic        hand_present;
  logic        presence_changed;
  logic [1:0]  swipe;
  logic [1:0]  motion;
  logic [14:0] level_q8;
  logic        level_changed;

  modport source (output valid, output filtered, output hand_present,
                  output presence_changed, output swipe, output motion,
                  output level_q8, output level_changed, input ready);
  modport sink   (input valid, input filtered, input hand_present,
                  input presence_changed, input swipe, input motion,
                  input level_q8, input level_changed, output ready);
endinterface

// ===== src/distance_gesture_volume_tracker_unit.sv =====
// Top level of the distance gesture volume tracker.
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        sample[9:0], now_ms[31:0]
//  out_ch   out  valid/ready        filtered, hand_present, presence_changed,
//                                   swipe, motion, level_q8, level_changed
//  cfg_*    in   cfg_we (no wait)   cfg_idx[2:0], cfg_data[15:0]
//
// One item passes through three serial steps: the median walks the window with one
// comparator, the trend scan visits history entries one per cycle, and the level step
// runs a one-bit-per-cycle divider.
// in_ch.ready is high only while idle; a result held in the output register does
// not block the next item, only the final write-back waits for out_ch.ready.
// Synchronous active-low reset restores the register defaults and clears the control state, window and history.
module distance_gesture_volume_tracker_unit import dgvt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dgvt_in_if.sink           in_ch,
  dgvt_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_data
);

  // configuration registers
  logic [9:0]  smin_r, smax_r, thr_r, step_r, db_r;
  logic [6:0]  omin_r, omax_r;
  logic [15:0] pause_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smin_r  <= 10'd100;
      smax_r  <= 10'd600;
      omin_r  <= 7'd0;
      omax_r  <= 7'd127;
      pause_r <= 16'd1000;
      thr_r   <= 10'd100;
      step_r  <= 10'd50;
      db_r    <= 10'd10;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_SENSOR_MIN: smin_r  <= cfg_data[9:0];
        REG_SENSOR_MAX: smax_r  <= cfg_data[9:0];
        REG_OUTPUT_MIN: omin_r  <= cfg_data[6:0];
        REG_OUTPUT_MAX: omax_r  <= cfg_data[6:0];
        REG_PAUSE_MS:   pause_r <= cfg_data;
        REG_SPAN_THR:   thr_r   <= cfg_data[9:0];
        REG_MAX_STEP:   step_r  <= cfg_data[9:0];
        REG_DEADBAND:   db_r    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // sequencer and tracker state
  top_state_t  st_r, st_nxt;
  val_t        win_r [MEDIAN_TAPS];
  val_t        hist_r [HISTORY_DEPTH];
  logic        hand_r, hand_nxt, prev_hand_r, prev_hand_nxt;
  logic        cvalid_r, cvalid_nxt;
  ctr_t        centre_r, centre_nxt, shift_r, shift_nxt;
  logic [31:0] now_r, now_nxt, last_r, last_nxt;
  logic [14:0] level_r, level_nxt, prev_level_r, prev_level_nxt;
  swipe_t      swipe_r, swipe_nxt;
  motion_t     motion_r, motion_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic        neg_r, neg_nxt;
  logic signed [DVD_W:0]    d_r, d_nxt;

  // result register
  logic        ov_r, ov_nxt, o_hand_r, o_hand_nxt, o_pchg_r, o_pchg_nxt;
  logic        o_lchg_r, o_lchg_nxt;
  val_t        o_filt_r, o_filt_nxt;
  swipe_t      o_swipe_r, o_swipe_nxt;
  motion_t     o_motion_r, o_motion_nxt;
  logic [14:0] o_level_r, o_level_nxt;

  // submodule handshakes
  logic             accept, med_start, med_done, scan_start, scan_done;
  logic             div_start, div_done;
  val_t             med, mapped, h;
  swipe_t           scan_res;
  logic [DVD_W-1:0] quo, dvd;
  logic [PROD_W-1:0] prod_mag;
  ctr_t             hc, db_c, up_lim, dn_lim;
  logic signed [7:0]  orange;
  logic signed [10:0] srange;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [DVD_W+1:0] sum, omax256, omin256;

  dgvt_median u_median (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (med_start),
    .window (win_r),
    .done   (med_done),
    .med    (med)
  );

  dgvt_trend u_trend (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .hist     (hist_r),
    .span_thr (thr_r),
    .max_step (step_r),
    .done     (scan_done),
    .result   (scan_res)
  );

  dgvt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (srange[9:0]),
    .done     (div_done),
    .quotient (quo)
  );

  assign in_ch.ready = (st_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // edge samples count as invalid
  assign mapped = (in_ch.sample > smin_r && in_ch.sample < smax_r) ?
                  val_t'({1'b0, smax_r} - {1'b0, in_ch.sample}) : VAL_NONE;

  // window and history shift lines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MEDIAN_TAPS; i++)   win_r[i]  <= VAL_NONE;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_r[i] <= '0;
    end else begin
      if (accept) begin
        for (int i = MEDIAN_TAPS - 1; i > 0; i--) win_r[i] <= win_r[i-1];
        win_r[0] <= mapped;
      end
      if (st_r == ST_MEDIAN && med_done) begin
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist_r[i] <= hist_r[i-1];
        hist_r[0] <= med;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      hand_r       <= 1'b0;
      prev_hand_r  <= 1'b0;
      cvalid_r     <= 1'b0;
      centre_r     <= '0;
      last_r       <= '0;
      level_r      <= '0;
      prev_level_r <= '0;
      ov_r         <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      hand_r       <= hand_nxt;
      prev_hand_r  <= prev_hand_nxt;
      cvalid_r     <= cvalid_nxt;
      centre_r     <= centre_nxt;
      last_r       <= last_nxt;
      level_r      <= level_nxt;
      prev_level_r <= prev_level_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    swipe_r    <= swipe_nxt;
    motion_r   <= motion_nxt;
    shift_r    <= shift_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    d_r        <= d_nxt;
    o_filt_r   <= o_filt_nxt;
    o_hand_r   <= o_hand_nxt;
    o_pchg_r   <= o_pchg_nxt;
    o_swipe_r  <= o_swipe_nxt;
    o_motion_r <= o_motion_nxt;
    o_level_r  <= o_level_nxt;
    o_lchg_r   <= o_lchg_nxt;
  end

  always_comb begin
    // tracker arithmetic
    h       = hist_r[0];
    hc      = {{(CTR_W-VAL_W){h[VAL_W-1]}}, h};
    db_c    = $signed({{(CTR_W-10){1'b0}}, db_r});
    up_lim  = centre_r + db_c;
    dn_lim  = centre_r - db_c;
    orange  = $signed({1'b0, omax_r}) - $signed({1'b0, omin_r});
    srange  = $signed({1'b0, smax_r}) - $signed({1'b0, smin_r});
    prod_full = shift_r * orange;
    prod_mag  = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    dvd       = {prod_mag, 8'b0};
    sum       = $signed({{(DVD_W+2-15){1'b0}}, level_r}) + (DVD_W+2)'(d_r);
    omax256   = $signed({{(DVD_W+2-15){1'b0}}, omax_r, 8'b0});
    omin256   = $signed({{(DVD_W+2-15){1'b0}}, omin_r, 8'b0});

    st_nxt         = st_r;
    hand_nxt       = hand_r;
    prev_hand_nxt  = prev_hand_r;
    cvalid_nxt     = cvalid_r;
    centre_nxt     = centre_r;
    now_nxt        = now_r;
    last_nxt       = last_r;
    level_nxt      = level_r;
    prev_level_nxt = prev_level_r;
    swipe_nxt      = swipe_r;
    motion_nxt     = motion_r;
    shift_nxt      = shift_r;
    prod_nxt       = prod_r;
    neg_nxt        = neg_r;
    d_nxt          = d_r;
    med_start      = 1'b0;
    scan_start     = 1'b0;
    div_start      = 1'b0;
    ov_nxt         = ov_r && !out_ch.ready;
    o_filt_nxt     = o_filt_r;
    o_hand_nxt     = o_hand_r;
    o_pchg_nxt     = o_pchg_r;
    o_swipe_nxt    = o_swipe_r;
    o_motion_nxt   = o_motion_r;
    o_level_nxt    = o_level_r;
    o_lchg_nxt     = o_lchg_r;

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          now_nxt        = in_ch.now_ms;
          prev_hand_nxt  = hand_r;
          prev_level_nxt = level_r;
          swipe_nxt      = SWIPE_NONE;
          motion_nxt     = MOT_STOP;
          st_nxt         = ST_MEDGO;
        end
      end
      ST_MEDGO: begin
        med_start = 1'b1;
        st_nxt    = ST_MEDIAN;
      end
      ST_MEDIAN: begin
        if (med_done) begin
          hand_nxt = !med[VAL_W-1];
          st_nxt   = ST_PAUSE;
        end
      end
      ST_PAUSE: begin
        // swipes are looked for only once the pause since the last one is over
        if ((now_r - last_r) > {16'b0, pause_r}) begin
          scan_start = 1'b1;
          st_nxt     = ST_SCAN;
        end else begin
          st_nxt = ST_TRACK;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          swipe_nxt = scan_res;
          case (scan_res)
            SWIPE_ON: begin
              level_nxt  = {omax_r, 8'b0};
              last_nxt   = now_r;
              motion_nxt = MOT_UP;
              st_nxt     = ST_FINISH;
            end
            SWIPE_OFF: begin
              level_nxt  = {omin_r, 8'b0};
              last_nxt   = now_r;
              motion_nxt = MOT_DOWN;
              st_nxt     = ST_FINISH;
            end
            default: st_nxt = ST_TRACK;
          endcase
        end
      end
      ST_TRACK: begin
        // deadband tracker around the hand centre
        shift_nxt = '0;
        if (h > 0) begin
          if (!cvalid_r) begin
            centre_nxt = hc;
            cvalid_nxt = 1'b1;
          end else if (hc > up_lim) begin
            shift_nxt  = hc - up_lim;
            centre_nxt = hc - db_c;
            motion_nxt = MOT_UP;
          end else if (hc < dn_lim) begin
            shift_nxt  = hc - dn_lim;
            centre_nxt = hc + db_c;
            motion_nxt = MOT_DOWN;
          end
        end else begin
          cvalid_nxt = 1'b0;
        end
        st_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt = prod_full;
        st_nxt   = ST_DIVGO;
      end
      ST_DIVGO: begin
        // no step when the sensor range is empty
        if (srange > 0 && prod_r != 0) begin
          neg_nxt   = prod_r[PROD_W-1];
          div_start = 1'b1;
          st_nxt    = ST_DIV;
        end else begin
          d_nxt  = '0;
          st_nxt = ST_CLAMP;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          d_nxt  = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
          st_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (sum > omax256)      level_nxt = omax256[14:0];
        else if (sum < omin256) level_nxt = omin256[14:0];
        else                    level_nxt = sum[14:0];
        st_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt       = 1'b1;
          o_filt_nxt   = hist_r[0];
          o_hand_nxt   = hand_r;
          o_pchg_nxt   = (hand_r != prev_hand_r);
          o_swipe_nxt  = swipe_r;
          o_motion_nxt = motion_r;
          o_level_nxt  = level_r;
          o_lchg_nxt   = (level_r != prev_level_r);
          st_nxt       = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.filtered         = o_filt_r;
  assign out_ch.hand_present     = o_hand_r;
  assign out_ch.presence_changed = o_pchg_r;
  assign out_ch.swipe            = o_swipe_r;
  assign out_ch.motion           = o_motion_r;
  assign out_ch.level_q8         = o_level_r;
  assign out_ch.level_changed    = o_lchg_r;

endmodule

// ===== src/dgvt_median.sv =====
// Serial rank-count median over the sample window, one compare per cycle.
module dgvt_median import dgvt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t window [MEDIAN_TAPS],
  output logic done,
  output val_t med
);

  med_state_t        st_r, st_nxt;
  logic [MED_IW-1:0] i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt, addr, rank_sum;
  val_t              wi_r, wi_nxt, med_r, med_nxt, rd;
  logic              done_r, done_nxt, gt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    rank_r <= rank_nxt;
    wi_r   <= wi_nxt;
    med_r  <= med_nxt;
  end

  always_comb begin
    addr     = (st_r == MS_LOAD) ? i_r : j_r;
    rd       = window[addr];
    // rank of element i in a stable descending sort
    gt       = (rd > wi_r) || ((rd == wi_r) && (j_r < i_r));
    rank_sum = rank_r + MED_IW'(gt);
    st_nxt   = st_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    rank_nxt = rank_r;
    wi_nxt   = wi_r;
    med_nxt  = med_r;
    done_nxt = 1'b0;
    case (st_r)
      MS_IDLE: begin
        if (start) begin
          i_nxt  = '0;
          st_nxt = MS_LOAD;
        end
      end
      MS_LOAD: begin
        wi_nxt   = rd;
        j_nxt    = '0;
        rank_nxt = '0;
        st_nxt   = MS_CMP;
      end
      MS_CMP: begin
        rank_nxt = rank_sum;
        if (j_r == MED_IW'(MEDIAN_TAPS - 1)) begin
          if (rank_sum == MED_IW'(MEDIAN_TAPS / 2)) begin
            med_nxt  = wi_r;
            done_nxt = 1'b1;
            st_nxt   = MS_IDLE;
          end else begin
            i_nxt  = i_r + MED_IW'(1);
            st_nxt = MS_LOAD;
          end
        end else begin
          j_nxt = j_r + MED_IW'(1);
        end
      end
      default: st_nxt = MS_IDLE;
    endcase
  end

  assign done = done_r;
  assign med  = med_r;

endmodule

// ===== src/dgvt_trend.sv =====
// Serial trend scan over the history line; reports on, off or no swipe.
module dgvt_trend import dgvt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  val_t       hist [HISTORY_DEPTH],
  input  logic [9:0] span_thr,
  input  logic [9:0] max_step,
  output logic       done,
  output swipe_t     result
);

  localparam logic [HIST_IW-1:0] LB = HIST_IW'(HISTORY_DEPTH - 1);

  trend_state_t       st_r, st_nxt;
  logic [HIST_IW-1:0] j_r, j_nxt, k_r, k_nxt, on_r, on_nxt, off_r, off_nxt, ptr;
  logic [NOISE_W-1:0] noise_r, noise_nxt, noise_n;
  val_t               hj_r, hj_nxt, rd, h0, hl;
  logic               up_r, up_nxt, abort_r, abort_nxt, done_r, done_nxt, brk, pre_ok;
  swipe_t             res_r, res_nxt;
  logic signed [VAL_W:0] full, mag, g, stp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= TS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    on_r    <= on_nxt;
    off_r   <= off_nxt;
    noise_r <= noise_nxt;
    hj_r    <= hj_nxt;
    up_r    <= up_nxt;
    abort_r <= abort_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    h0     = hist[0];
    hl     = hist[LB];
    full   = {h0[VAL_W-1], h0} - {hl[VAL_W-1], hl};
    mag    = full[VAL_W] ? -full : full;
    pre_ok = (h0 > 0) && (hl > 0) && (mag > $signed({2'b00, span_thr}));
    ptr    = (st_r == TS_K) ? k_r : j_r;
    rd     = hist[ptr];
    g      = {hj_r[VAL_W-1], hj_r} - {rd[VAL_W-1], rd};
    stp    = $signed({2'b00, max_step});
    st_nxt    = st_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    on_nxt    = on_r;
    off_nxt   = off_r;
    noise_nxt = noise_r;
    noise_n   = noise_r;
    hj_nxt    = hj_r;
    up_nxt    = up_r;
    abort_nxt = abort_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    brk       = 1'b0;
    case (st_r)
      TS_IDLE: begin
        if (start) begin
          on_nxt    = '0;
          off_nxt   = '0;
          noise_nxt = '0;
          abort_nxt = 1'b0;
          j_nxt     = '0;
          up_nxt    = (full > 0);
          st_nxt    = pre_ok ? TS_J : TS_DONE;
        end
      end
      TS_J: begin
        if (j_r == LB) begin
          st_nxt = TS_DONE;
        end else if (rd <= 0) begin
          j_nxt = j_r + HIST_IW'(1);
        end else begin
          hj_nxt = rd;
          k_nxt  = j_r + HIST_IW'(1);
          st_nxt = TS_K;
        end
      end
      TS_K: begin
        // a gap search that runs into the oldest entry ends the scan empty
        if ((k_r == LB) && (k_r != j_r + HIST_IW'(1))) begin
          abort_nxt = 1'b1;
          st_nxt    = TS_DONE;
        end else if (rd >= 0) begin
          if (rd > 0) begin
            if (up_r) begin
              if (g >= 0 && g < stp) on_nxt = on_r + HIST_IW'(1);
              else if (g >= stp)     brk = 1'b1;
              else                   noise_n = noise_r + NOISE_W'(1);
            end else begin
              if (g <= 0 && g > -stp) off_nxt = off_r + HIST_IW'(1);
              else if (g <= -stp)     brk = 1'b1;
              else                    noise_n = noise_r + NOISE_W'(1);
            end
            if (int'(noise_n) >= NOISE_LIMIT) brk = 1'b1;
          end
          noise_nxt = noise_n;
          if (brk) begin
            st_nxt = TS_DONE;
          end else begin
            j_nxt  = j_r + HIST_IW'(1);
            st_nxt = TS_J;
          end
        end else begin
          k_nxt = k_r + HIST_IW'(1);
        end
      end
      TS_DONE: begin
        done_nxt = 1'b1;
        if (abort_r)                    res_nxt = SWIPE_NONE;
        else if (int'(on_r) > TREND_MIN)  res_nxt = SWIPE_ON;
        else if (int'(off_r) > TREND_MIN) res_nxt = SWIPE_OFF;
        else                            res_nxt = SWIPE_NONE;
        st_nxt = TS_IDLE;
      end
      default: st_nxt = TS_IDLE;
    endcase
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== src/dgvt_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module dgvt_div import dgvt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [9:0]       divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic              busy_r, busy_nxt, done_r, done_nxt, qbit;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [9:0]        rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [10:0]       trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  always_comb begin
    trial    = {rem_r, q_r[DVD_W-1]};
    qbit     = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (busy_r) begin
      rem_nxt = qbit ? 10'(trial - {1'b0, dvs_r}) : trial[9:0];
      q_nxt   = {q_r[DVD_W-2:0], qbit};
      cnt_nxt = cnt_r - DIV_CW'(1);
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CW'(DVD_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      q_nxt    = dividend;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
